@@ rtl/hamm_pkg.sv @@
// Shared types and constants for the nth Hamming number unit.
// Used by hamm_ctrl, hamm_dp and nth_hamming_number_unit; depends on nothing.
`timescale 1ns / 1ps

package hamm_pkg;

  // Default table depth (largest index that may be requested)
  localparam int MAX_N_DEF = 1024;
  // Width of the requested index field
  localparam int IDX_W = 14;
  // Width of a Hamming value (table entry, candidate, result)
  localparam int VAL_W = 63;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MIN,
    ST_WRITE,
    ST_RD_TWO,
    ST_RD_THREE,
    ST_RD_FIVE,
    ST_CAP_FIVE,
    ST_FINISH
  } hamm_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;      // capture index, seed table and pointers
    logic take_min;   // register the smallest candidate
    logic write_step; // append the minimum, advance matching pointers
    logic rd_two;     // read table at pointer_two
    logic rd_three;   // read table at pointer_three, capture candidate_two
    logic rd_five;    // read table at pointer_five, capture candidate_three
    logic cap_five;   // capture candidate_five
    logic load_out;   // load the result register
  } hamm_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic err;  // index is zero or above MAX_N
    logic one;  // index is one, no generation needed
    logic last; // the entry being written is the requested one
  } hamm_status_t;

endpackage

@@ rtl/nth_hamming_number_unit.sv @@
// An index of one or a bad index goes from the check straight to the result; any other index
// first generates the table up to entry n. Either way the result may wait for the result slot.
// Each generated entry but the last takes six controller steps: minimum, table write,
// three table reads through the single read port (one for each pointer) and a final capture.
// One item is worked at a time; the next can be accepted in the cycle after the result is loaded,
// even while that result waits.
// Reset (rst, synchronous) clears the controller and result valid; the table needs none.
`timescale 1ns / 1ps

module nth_hamming_number_unit #(
  parameter int MAX_N = hamm_pkg::MAX_N_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  logic [hamm_pkg::IDX_W-1:0] requested_index,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output logic [hamm_pkg::VAL_W-1:0] hamming_value,
  output logic                       index_error
);

  hamm_pkg::hamm_cmd_t    cmd;
  hamm_pkg::hamm_status_t status;

  hamm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .cmd       (cmd)
  );

  hamm_dp #(
    .MAX_N (MAX_N)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .requested_index (requested_index),
    .cmd             (cmd),
    .status          (status),
    .hamming_value   (hamming_value),
    .index_error     (index_error)
  );

  // An error result always carries a zero value
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && index_error) |-> (hamming_value == '0))
    else $error("error result with nonzero value");

endmodule

@@ rtl/hamm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; used by hamm_dp for the sequence table.
`timescale 1ns / 1ps

module hamm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/hamm_ctrl.sv @@
// Controller state machine for the nth Hamming number unit.
// Depends on hamm_pkg; drives hamm_dp through hamm_cmd_t commands.
`timescale 1ns / 1ps

module hamm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  input  hamm_pkg::hamm_status_t status,
  output hamm_pkg::hamm_cmd_t   cmd
);

  hamm_pkg::hamm_state_t state;
  hamm_pkg::hamm_state_t state_next;
  logic                  slot_free;

  // Result register can take a new item when empty or being drained
  assign slot_free = !rsp_valid || rsp_ready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hamm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      hamm_pkg::ST_IDLE: begin
        if (req_valid) state_next = hamm_pkg::ST_CHECK;
      end
      hamm_pkg::ST_CHECK: begin
        if (status.err || status.one) state_next = hamm_pkg::ST_FINISH;
        else                          state_next = hamm_pkg::ST_MIN;
      end
      hamm_pkg::ST_MIN:       state_next = hamm_pkg::ST_WRITE;
      hamm_pkg::ST_WRITE: begin
        if (status.last) state_next = hamm_pkg::ST_FINISH;
        else             state_next = hamm_pkg::ST_RD_TWO;
      end
      hamm_pkg::ST_RD_TWO:    state_next = hamm_pkg::ST_RD_THREE;
      hamm_pkg::ST_RD_THREE:  state_next = hamm_pkg::ST_RD_FIVE;
      hamm_pkg::ST_RD_FIVE:   state_next = hamm_pkg::ST_CAP_FIVE;
      hamm_pkg::ST_CAP_FIVE:  state_next = hamm_pkg::ST_MIN;
      hamm_pkg::ST_FINISH: begin
        if (slot_free) state_next = hamm_pkg::ST_IDLE;
      end
      default:                state_next = hamm_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      hamm_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        cmd.start = req_valid;
      end
      hamm_pkg::ST_MIN:      cmd.take_min   = 1'b1;
      hamm_pkg::ST_WRITE:    cmd.write_step = 1'b1;
      hamm_pkg::ST_RD_TWO:   cmd.rd_two     = 1'b1;
      hamm_pkg::ST_RD_THREE: cmd.rd_three   = 1'b1;
      hamm_pkg::ST_RD_FIVE:  cmd.rd_five    = 1'b1;
      hamm_pkg::ST_CAP_FIVE: cmd.cap_five   = 1'b1;
      hamm_pkg::ST_FINISH:   cmd.load_out   = slot_free;
      default: begin
        cmd       = '0;
        req_ready = 1'b0;
      end
    endcase
  end

  // Result valid: set on load, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // A result is never dropped before it is taken
  assert property (@(posedge clk) disable iff (rst)
    $fell(rsp_valid) |-> $past(rsp_ready))
    else $error("result dropped without handshake");

  // Leaving the finish state always presents a result
  assert property (@(posedge clk) disable iff (rst)
    (state == hamm_pkg::ST_FINISH && slot_free) |=> rsp_valid)
    else $error("finished item not presented");

endmodule

@@ rtl/hamm_dp.sv @@
// Datapath for the nth Hamming number unit: sequence table, pointers,
// candidates and result register. Depends on hamm_pkg and hamm_ram.
`timescale 1ns / 1ps

module hamm_dp #(
  parameter int MAX_N = hamm_pkg::MAX_N_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [hamm_pkg::IDX_W-1:0] requested_index,
  input  hamm_pkg::hamm_cmd_t        cmd,
  output hamm_pkg::hamm_status_t     status,
  output logic [hamm_pkg::VAL_W-1:0] hamming_value,
  output logic                       index_error
);

  localparam int AW = $clog2(MAX_N);
  localparam int PW = $clog2(MAX_N + 1);
  localparam int IW = hamm_pkg::IDX_W;
  localparam int VW = hamm_pkg::VAL_W;
  localparam logic [IW-1:0] LIMIT = IW'(MAX_N);

  logic [PW-1:0] n;
  logic          err;
  logic [PW-1:0] pos;
  logic [AW-1:0] ptr_two;
  logic [AW-1:0] ptr_three;
  logic [AW-1:0] ptr_five;
  logic [VW-1:0] cand_two;
  logic [VW-1:0] cand_three;
  logic [VW-1:0] cand_five;
  logic [VW-1:0] m;
  logic [VW-1:0] min_val;
  logic [VW-1:0] min_ab;

  logic          we;
  logic [AW-1:0] waddr;
  logic [VW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [VW-1:0] rdata;

  // Smallest of the three candidates
  assign min_ab  = (cand_three < cand_two) ? cand_three : cand_two;
  assign min_val = (cand_five < min_ab) ? cand_five : min_ab;

  // Table write: seed entry zero on start, append the minimum on each step
  assign we    = cmd.start || cmd.write_step;
  assign waddr = cmd.start ? '0 : pos[AW-1:0];
  assign wdata = cmd.start ? VW'(1) : m;

  // Table read address
  always_comb begin
    if (cmd.rd_two)        raddr = ptr_two;
    else if (cmd.rd_three) raddr = ptr_three;
    else                   raddr = ptr_five;
  end

  hamm_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_N)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Status to the controller
  assign status.err  = err;
  assign status.one  = (n == PW'(1));
  assign status.last = ((pos + PW'(1)) == n);

  // Pointers and step position
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= PW'(1);
      ptr_two   <= '0;
      ptr_three <= '0;
      ptr_five  <= '0;
    end else if (cmd.start) begin
      pos       <= PW'(1);
      ptr_two   <= '0;
      ptr_three <= '0;
      ptr_five  <= '0;
    end else if (cmd.write_step) begin
      pos <= pos + PW'(1);
      if (cand_two == m)   ptr_two   <= ptr_two + AW'(1);
      if (cand_three == m) ptr_three <= ptr_three + AW'(1);
      if (cand_five == m)  ptr_five  <= ptr_five + AW'(1);
    end
  end

  // Index check and capture
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      n   <= requested_index[PW-1:0];
      err <= (requested_index == '0) || (requested_index > LIMIT);
    end
  end

  // Candidates and minimum: seed on start, rescale entries read from the table
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cand_two   <= VW'(2);
      cand_three <= VW'(3);
      cand_five  <= VW'(5);
      m          <= VW'(1);
    end else begin
      if (cmd.take_min) m          <= min_val;
      if (cmd.rd_three) cand_two   <= rdata << 1;
      if (cmd.rd_five)  cand_three <= rdata + (rdata << 1);
      if (cmd.cap_five) cand_five  <= rdata + (rdata << 2);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      hamming_value <= err ? '0 : m;
      index_error   <= err;
    end
  end

  // Pointers only ever point at entries already written
  assert property (@(posedge clk) disable iff (rst)
    (PW'(ptr_two) < pos) && (PW'(ptr_three) < pos) && (PW'(ptr_five) < pos))
    else $error("pointer ahead of written entries");

  // Appended values strictly increase, so none repeats
  assert property (@(posedge clk) disable iff (rst)
    cmd.take_min |=> (m > $past(m)))
    else $error("sequence not strictly increasing");

endmodule
